>>> hw/rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// Shared types, opcodes, status codes and defaults of the slot table.
// ----------------------------------------------------------------------------
package gst_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int LEASE_BITS_DEF = 8;
  localparam int COORD_W        = 32;
  localparam int GEN_W          = 32;

  typedef logic [2:0]         op_t;
  typedef logic [2:0]         status_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GEN_W-1:0]   gen_t;

  // opcodes
  localparam op_t OP_CREATE     = 3'd0;
  localparam op_t OP_REMOVE     = 3'd1;
  localparam op_t OP_ACQUIRE    = 3'd2;
  localparam op_t OP_RELEASE    = 3'd3;
  localparam op_t OP_BUSY       = 3'd4;
  localparam op_t OP_FIND_COORD = 3'd5;
  localparam op_t OP_FIND_HDL   = 3'd6;

  // status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_BAD_INDEX = 3'd3;
  localparam status_t ST_UNDERFLOW = 3'd4;

endpackage

>>> hw/rtl/gst_if.sv
// ----------------------------------------------------------------------------
// gst_in_if / gst_out_if
// Valid/ready channels for request and response beats of the slot table.
// ----------------------------------------------------------------------------
interface gst_in_if #(
  parameter int SLOT_W = 6
);
  logic                 valid;
  logic                 ready;
  gst_pkg::op_t         opcode;
  gst_pkg::coord_t      coord_x;
  gst_pkg::coord_t      coord_y;
  gst_pkg::coord_t      coord_z;
  logic [SLOT_W-1:0]    slot_in;
  gst_pkg::gen_t        handle_generation;

  modport source (output valid, opcode, coord_x, coord_y, coord_z, slot_in,
                  handle_generation, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, coord_z, slot_in,
                  handle_generation, output ready);
endinterface

interface gst_out_if #(
  parameter int SLOT_W = 6
);
  logic                 valid;
  logic                 ready;
  gst_pkg::status_t     status;
  logic [SLOT_W-1:0]    slot_out;
  gst_pkg::gen_t        generation_out;
  logic                 slot_busy;

  modport source (output valid, status, slot_out, generation_out, slot_busy,
                  input ready);
  modport sink   (input valid, status, slot_out, generation_out, slot_busy,
                  output ready);
endinterface

>>> hw/rtl/generational_slot_table.sv
// ----------------------------------------------------------------------------
// generational_slot_table
// Coordinate-keyed slot table with generations, lease counts and a LIFO
// free stack; keys, metadata and the free stack live in block RAMs.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    opcode, coord_x/y/z, slot_in, handle_generation
//  out_ch    out   valid/ready    status, slot_out, generation_out, slot_busy
//
//  one request at a time; release and busy query pass through S_META, S_EXEC
//  and S_FIN (a bad index goes straight to S_FIN), coordinate operations scan
//  the key RAM one entry per cycle, and a create that pops the free stack
//  adds the S_POP and S_META states.
//  metadata of slots never allocated reads as zero through the slots_used
//  fill count, so reset needs no clearing pass. a stalled response holds in
//  the output register while the next request is taken.
// ----------------------------------------------------------------------------
module generational_slot_table #(
  parameter int SLOT_COUNT = gst_pkg::SLOT_COUNT_DEF,
  parameter int LEASE_BITS = gst_pkg::LEASE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gst_in_if.sink    in_ch,
  gst_out_if.source out_ch
);

  localparam int SW     = $clog2(SLOT_COUNT);
  localparam int KEY_W  = 3 * gst_pkg::COORD_W;
  localparam int META_W = 1 + gst_pkg::GEN_W + LEASE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_META = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [LEASE_BITS-1:0] LEASE_MAX = '1;
  localparam logic [SW:0]           COUNT_V   = (SW+1)'(SLOT_COUNT);

  logic [2:0]              state;
  gst_pkg::op_t            op;
  logic [KEY_W-1:0]        key;
  gst_pkg::gen_t           hgen;
  logic [SW:0]             idx;
  logic                    pend;
  logic [SW-1:0]           pidx;
  logic                    found;
  logic [SW-1:0]           s;
  logic                    m_inuse;
  gst_pkg::gen_t           m_gen;
  logic [LEASE_BITS-1:0]   m_lease;
  logic [SW:0]             free_top;
  logic [SW:0]             slots_used;

  gst_pkg::status_t        r_status;
  logic [SW-1:0]           r_slot;
  gst_pkg::gen_t           r_gen;
  logic                    r_busy;

  logic                    ov;
  gst_pkg::status_t        o_status;
  logic [SW-1:0]           o_slot;
  gst_pkg::gen_t           o_gen;
  logic                    o_busy;

  // ram ports
  logic [KEY_W-1:0]        key_rd;
  logic [META_W-1:0]       meta_rd;
  logic [SW-1:0]           stk_rd;
  logic [SW-1:0]           meta_raddr;
  logic [SW:0]             top_m1;
  logic                    key_we, meta_we, stk_we;
  logic [META_W-1:0]       meta_wd;

  // exec results
  gst_pkg::status_t        e_status;
  logic [SW-1:0]           e_slot;
  gst_pkg::gen_t           e_gen;
  logic                    e_busy;
  logic                    e_push;
  logic                    e_inuse;
  gst_pkg::gen_t           e_newgen;
  logic [LEASE_BITS-1:0]   e_lease;

  logic                    accept;
  logic                    hit;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign top_m1      = free_top - (SW+1)'(1);
  assign hit         = pend && (key_rd == key) && meta_rd[META_W-1];

  // metadata read address by phase
  always_comb begin
    case (state)
      S_IDLE:  meta_raddr = in_ch.slot_in;
      S_SCAN:  meta_raddr = idx[SW-1:0];
      S_POP:   meta_raddr = stk_rd;
      default: meta_raddr = s;
    endcase
  end

  gst_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(s), .wdata(key),
    .raddr(idx[SW-1:0]), .rdata(key_rd)
  );

  gst_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(s), .wdata(meta_wd),
    .raddr(meta_raddr), .rdata(meta_rd)
  );

  gst_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(free_top[SW-1:0]), .wdata(s),
    .raddr(top_m1[SW-1:0]), .rdata(stk_rd)
  );

  // read-modify-write of one slot's metadata
  always_comb begin
    e_status = gst_pkg::ST_NOT_FOUND;
    e_slot   = '0;
    e_gen    = '0;
    e_busy   = 1'b0;
    e_push   = 1'b0;
    e_inuse  = m_inuse;
    e_newgen = m_gen + gst_pkg::gen_t'(1);
    e_lease  = m_lease;
    key_we   = 1'b0;
    meta_we  = 1'b0;
    if (e_newgen == '0) begin
      e_newgen = gst_pkg::gen_t'(1);
    end
    case (op)
      gst_pkg::OP_CREATE: begin
        e_status = gst_pkg::ST_OK;
        e_slot   = s;
        e_busy   = (m_lease != '0);
        if (found) begin
          e_gen = m_gen;
        end else begin
          e_gen   = e_newgen;
          e_inuse = 1'b1;
          key_we  = 1'b1;
          meta_we = 1'b1;
        end
      end
      gst_pkg::OP_REMOVE: begin
        if (found) begin
          e_status = gst_pkg::ST_OK;
          e_slot   = s;
          e_busy   = (m_lease != '0);
          e_inuse  = 1'b0;
          e_push   = (m_lease == '0);
          meta_we  = 1'b1;
        end
      end
      gst_pkg::OP_ACQUIRE: begin
        if (found) begin
          if (m_lease != LEASE_MAX) begin
            e_lease = m_lease + LEASE_BITS'(1);
          end
          e_status = gst_pkg::ST_OK;
          e_slot   = s;
          e_busy   = (e_lease != '0);
          meta_we  = 1'b1;
        end
      end
      gst_pkg::OP_RELEASE: begin
        e_slot = s;
        if (m_lease == '0) begin
          e_status = gst_pkg::ST_UNDERFLOW;
        end else begin
          e_lease  = m_lease - LEASE_BITS'(1);
          e_status = gst_pkg::ST_OK;
          e_busy   = (e_lease != '0);
          e_push   = !m_inuse && (e_lease == '0);
          meta_we  = 1'b1;
        end
      end
      gst_pkg::OP_BUSY: begin
        e_status = gst_pkg::ST_OK;
        e_slot   = s;
        e_busy   = (m_lease != '0);
      end
      gst_pkg::OP_FIND_COORD, gst_pkg::OP_FIND_HDL: begin
        if (found && (op == gst_pkg::OP_FIND_COORD || m_gen == hgen)) begin
          e_status = gst_pkg::ST_OK;
          e_slot   = s;
          e_busy   = (m_lease != '0);
        end
      end
      default: ;
    endcase
    if (state != S_EXEC) begin
      key_we  = 1'b0;
      meta_we = 1'b0;
      e_push  = 1'b0;
    end
    meta_wd = {e_inuse, (op == gst_pkg::OP_CREATE) ? e_gen : m_gen, e_lease};
    stk_we  = e_push && (free_top < COUNT_V);
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_top   <= '0;
      slots_used <= '0;
      pend       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= in_ch.opcode;
            key   <= {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
            hgen  <= in_ch.handle_generation;
            idx   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            s     <= in_ch.slot_in;
            r_status <= gst_pkg::ST_NOT_FOUND;
            r_slot   <= '0;
            r_gen    <= '0;
            r_busy   <= 1'b0;
            case (in_ch.opcode)
              gst_pkg::OP_CREATE, gst_pkg::OP_REMOVE, gst_pkg::OP_ACQUIRE,
              gst_pkg::OP_FIND_COORD: begin
                state <= S_SCAN;
              end
              gst_pkg::OP_FIND_HDL: begin
                state <= (in_ch.handle_generation == '0) ? S_FIN : S_SCAN;
              end
              gst_pkg::OP_RELEASE, gst_pkg::OP_BUSY: begin
                if ({1'b0, in_ch.slot_in} >= slots_used) begin
                  r_status <= gst_pkg::ST_BAD_INDEX;
                  r_slot   <= in_ch.slot_in;
                  state    <= S_FIN;
                end else begin
                  found <= 1'b1;
                  state <= S_META;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            found   <= 1'b1;
            s       <= pidx;
            m_inuse <= meta_rd[META_W-1];
            m_gen   <= meta_rd[LEASE_BITS +: gst_pkg::GEN_W];
            m_lease <= meta_rd[LEASE_BITS-1:0];
            state   <= S_EXEC;
          end else if (idx < slots_used) begin
            pend <= 1'b1;
            pidx <= idx[SW-1:0];
            idx  <= idx + (SW+1)'(1);
          end else if (op != gst_pkg::OP_CREATE) begin
            state <= S_EXEC;
          end else if (free_top != '0) begin
            free_top <= top_m1;
            state    <= S_POP;
          end else if (slots_used < COUNT_V) begin
            s          <= slots_used[SW-1:0];
            slots_used <= slots_used + (SW+1)'(1);
            m_inuse    <= 1'b0;
            m_gen      <= '0;
            m_lease    <= '0;
            state      <= S_EXEC;
          end else begin
            r_status <= gst_pkg::ST_FULL;
            state    <= S_FIN;
          end
        end
        S_POP: begin
          s     <= stk_rd;
          state <= S_META;
        end
        S_META: begin
          m_inuse <= meta_rd[META_W-1];
          m_gen   <= meta_rd[LEASE_BITS +: gst_pkg::GEN_W];
          m_lease <= meta_rd[LEASE_BITS-1:0];
          state   <= S_EXEC;
        end
        S_EXEC: begin
          r_status <= e_status;
          r_slot   <= e_slot;
          r_gen    <= e_gen;
          r_busy   <= e_busy;
          if (stk_we) begin
            free_top <= free_top + (SW+1)'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!ov || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_FIN && (!ov || out_ch.ready)) begin
      ov       <= 1'b1;
      o_status <= r_status;
      o_slot   <= r_slot;
      o_gen    <= r_gen;
      o_busy   <= r_busy;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  assign out_ch.valid          = ov;
  assign out_ch.status         = o_status;
  assign out_ch.slot_out       = o_slot;
  assign out_ch.generation_out = o_gen;
  assign out_ch.slot_busy      = o_busy;

  // checks
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    free_top <= slots_used) else $error("free stack deeper than slots used");

  a_used_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> slots_used >= $past(slots_used))
    else $error("slots used decreased");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE) else $error("request accepted without work");

endmodule

>>> hw/rtl/gst_ram.sv
// ----------------------------------------------------------------------------
// gst_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/generational_slot_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_slot_table_tb
// Drives request beats into the slot table from a directed table and then
// from random coordinate-reuse sequences, models the table on the side and
// compares every response beat against the modeled or typed-in result.
// ----------------------------------------------------------------------------
module generational_slot_table_tb;

  localparam int NSLOT = 64;
  localparam int LMAX  = 255;

  typedef struct packed {
    gst_pkg::op_t    op;
    gst_pkg::coord_t x;
    gst_pkg::coord_t y;
    gst_pkg::coord_t z;
    logic [5:0]      sidx;
    gst_pkg::gen_t   hgen;
  } req_t;

  typedef struct packed {
    gst_pkg::status_t st;
    logic [5:0]       slot;
    gst_pkg::gen_t    gen;
    logic             busy;
  } rsp_t;

  // directed row: request plus optional typed-in response
  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  gst_in_if  #(.SLOT_W(6)) in_ch ();
  gst_out_if #(.SLOT_W(6)) out_ch ();

  generational_slot_table #(.SLOT_COUNT(NSLOT), .LEASE_BITS(8)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // shadow copy of the table
  gst_pkg::coord_t kx [NSLOT];
  gst_pkg::coord_t ky [NSLOT];
  gst_pkg::coord_t kz [NSLOT];
  logic            bound [NSLOT];
  gst_pkg::gen_t   gens [NSLOT];
  int unsigned     leases [NSLOT];
  int unsigned     freelist [$];
  int unsigned     used_cnt;

  rsp_t pending_rsp [$];
  int   errors = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  bit   hold_off = 0;

  // small coordinate pool so creates, removes and leases collide often
  gst_pkg::coord_t pool_x [8];
  gst_pkg::coord_t pool_y [8];
  gst_pkg::coord_t pool_z [8];

  function automatic int find_slot(gst_pkg::coord_t x, gst_pkg::coord_t y,
                                   gst_pkg::coord_t z);
    for (int i = 0; i < NSLOT; i++)
      if (bound[i] && kx[i] == x && ky[i] == y && kz[i] == z) return i;
    return -1;
  endfunction

  function automatic rsp_t table_step(req_t r);
    rsp_t o;
    int f;
    int unsigned s;
    o = '{st: gst_pkg::ST_NOT_FOUND, slot: '0, gen: '0, busy: 1'b0};
    case (r.op)
      gst_pkg::OP_CREATE: begin
        f = find_slot(r.x, r.y, r.z);
        if (f >= 0) s = f;
        else if (freelist.size() > 0) s = freelist.pop_back();
        else if (used_cnt < NSLOT) begin
          s = used_cnt;
          used_cnt++;
        end else begin
          o.st = gst_pkg::ST_FULL;
          return o;
        end
        if (f < 0) begin
          kx[s] = r.x; ky[s] = r.y; kz[s] = r.z;
          gens[s] = gens[s] + 1;
          if (gens[s] == 0) gens[s] = 1;
          bound[s] = 1'b1;
        end
        o = '{st: gst_pkg::ST_OK, slot: s, gen: gens[s], busy: leases[s] != 0};
      end
      gst_pkg::OP_REMOVE: begin
        f = find_slot(r.x, r.y, r.z);
        if (f >= 0) begin
          bound[f] = 1'b0;
          if (leases[f] == 0 && freelist.size() < NSLOT) freelist.push_back(f);
          o = '{st: gst_pkg::ST_OK, slot: f, gen: '0, busy: leases[f] != 0};
        end
      end
      gst_pkg::OP_ACQUIRE: begin
        f = find_slot(r.x, r.y, r.z);
        if (f >= 0) begin
          if (leases[f] < LMAX) leases[f]++;
          o = '{st: gst_pkg::ST_OK, slot: f, gen: '0, busy: 1'b1};
        end
      end
      gst_pkg::OP_RELEASE: begin
        o.slot = r.sidx;
        if (r.sidx >= used_cnt) o.st = gst_pkg::ST_BAD_INDEX;
        else if (leases[r.sidx] == 0) o.st = gst_pkg::ST_UNDERFLOW;
        else begin
          leases[r.sidx]--;
          if (!bound[r.sidx] && leases[r.sidx] == 0 && freelist.size() < NSLOT)
            freelist.push_back(r.sidx);
          o.st = gst_pkg::ST_OK;
          o.busy = leases[r.sidx] != 0;
        end
      end
      gst_pkg::OP_BUSY: begin
        o.slot = r.sidx;
        if (r.sidx >= used_cnt) o.st = gst_pkg::ST_BAD_INDEX;
        else begin
          o.st = gst_pkg::ST_OK;
          o.busy = leases[r.sidx] != 0;
        end
      end
      gst_pkg::OP_FIND_COORD, gst_pkg::OP_FIND_HDL: begin
        f = (r.op == gst_pkg::OP_FIND_HDL && r.hgen == 0) ? -1 :
            find_slot(r.x, r.y, r.z);
        if (f >= 0 && !(r.op == gst_pkg::OP_FIND_HDL && gens[f] != r.hgen))
          o = '{st: gst_pkg::ST_OK, slot: f, gen: '0, busy: leases[f] != 0};
      end
      default: ;
    endcase
    return o;
  endfunction

  // request side; valid stays up into the next beat when no idle follows
  task automatic send_req(req_t r);
    while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.op;
    in_ch.coord_x <= r.x;
    in_ch.coord_y <= r.y;
    in_ch.coord_z <= r.z;
    in_ch.slot_in <= r.sidx;
    in_ch.handle_generation <= r.hgen;
    do @(posedge clk); while (!in_ch.ready);
    pending_rsp.push_back(table_step(r));
  endtask

  // response side: random stall unless a long hold-off is running
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && !(snk_stall_pct > 0 &&
                      $urandom_range(99, 0) < snk_stall_pct);
    end
  end

  // response beat check
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing expected");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_ch.status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_ch.status); errors++;
        end
        if (out_ch.slot_out !== e.slot) begin
          $error("slot_out exp %0d got %0d", e.slot, out_ch.slot_out); errors++;
        end
        if (out_ch.generation_out !== e.gen) begin
          $error("generation_out exp %0d got %0d", e.gen, out_ch.generation_out);
          errors++;
        end
        if (out_ch.slot_busy !== e.busy) begin
          $error("slot_busy exp %0d got %0d", e.busy, out_ch.slot_busy); errors++;
        end
      end
    end
  end

  function automatic req_t mk(gst_pkg::op_t op, gst_pkg::coord_t x,
                              gst_pkg::coord_t y, gst_pkg::coord_t z,
                              logic [5:0] s, gst_pkg::gen_t g);
    req_t r;
    r = '{op: op, x: x, y: y, z: z, sidx: s, hgen: g};
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int p;
    int k;
    p = $urandom_range(99, 0);
    k = $urandom_range(7, 0);
    r = mk(gst_pkg::OP_CREATE, pool_x[k], pool_y[k], pool_z[k],
           $urandom_range(63, 0), 0);
    if (p < 30) r.op = gst_pkg::OP_CREATE;
    else if (p < 45) r.op = gst_pkg::OP_REMOVE;
    else if (p < 60) r.op = gst_pkg::OP_ACQUIRE;
    else if (p < 72) r.op = gst_pkg::OP_RELEASE;
    else if (p < 78) r.op = gst_pkg::OP_BUSY;
    else if (p < 84) r.op = gst_pkg::OP_FIND_COORD;
    else if (p < 94) r.op = gst_pkg::OP_FIND_HDL;
    else r.op = gst_pkg::op_t'($urandom_range(7, 0));
    // valid handles mostly, stale or zero now and then
    k = find_slot(r.x, r.y, r.z);
    if (k >= 0 && $urandom_range(3, 0) != 0) r.hgen = gens[k];
    else r.hgen = ($urandom_range(1, 0) != 0) ? $urandom() : '0;
    if ((r.op == gst_pkg::OP_RELEASE || r.op == gst_pkg::OP_BUSY) && used_cnt > 0 &&
        $urandom_range(3, 0) != 0)
      r.sidx = $urandom_range(used_cnt - 1, 0);
    // occasional fresh coordinate, full random bits
    if ($urandom_range(9, 0) == 0) begin
      r.x = $urandom(); r.y = $urandom(); r.z = $urandom();
    end
    return r;
  endfunction

  row_t rows [$];

  initial begin
    req_t r;
    in_ch.valid = 1'b0;
    in_ch.opcode = gst_pkg::OP_CREATE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.slot_in = '0;
    in_ch.handle_generation = '0;
    for (int i = 0; i < NSLOT; i++) begin
      bound[i] = 0; gens[i] = 0; leases[i] = 0;
    end
    used_cnt = 0;
    for (int i = 0; i < 8; i++) begin
      pool_x[i] = $urandom(); pool_y[i] = $urandom(); pool_z[i] = $urandom();
    end
    pool_x[0] = 32'h8000_0000; pool_y[0] = 32'h7fff_ffff; pool_z[0] = 32'hffff_ffff;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed responses for reset-state, error and basic cases
    rows.push_back('{mk(gst_pkg::OP_BUSY, 0, 0, 0, 0, 0), 1,
                     '{gst_pkg::ST_BAD_INDEX, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_RELEASE, 0, 0, 0, 63, 0), 1,
                     '{gst_pkg::ST_BAD_INDEX, 63, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_FIND_COORD, 1, 2, 3, 0, 0), 1,
                     '{gst_pkg::ST_NOT_FOUND, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_REMOVE, 1, 2, 3, 0, 0), 1,
                     '{gst_pkg::ST_NOT_FOUND, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_CREATE, 32'h8000_0000, 32'h7fff_ffff,
                        32'hffff_ffff, 0, 0), 1, '{gst_pkg::ST_OK, 0, 1, 0}});
    rows.push_back('{mk(gst_pkg::OP_CREATE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0),
                     1, '{gst_pkg::ST_OK, 1, 1, 0}});
    rows.push_back('{mk(gst_pkg::OP_CREATE, 32'h8000_0000, 32'h7fff_ffff,
                        32'hffff_ffff, 0, 0), 1, '{gst_pkg::ST_OK, 0, 1, 0}});
    rows.push_back('{mk(gst_pkg::OP_FIND_HDL, 32'h8000_0000, 32'h7fff_ffff,
                        32'hffff_ffff, 0, 0), 1, '{gst_pkg::ST_NOT_FOUND, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_FIND_HDL, 32'h8000_0000, 32'h7fff_ffff,
                        32'hffff_ffff, 0, 32'hffff_ffff), 1,
                     '{gst_pkg::ST_NOT_FOUND, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_FIND_HDL, 32'h8000_0000, 32'h7fff_ffff,
                        32'hffff_ffff, 0, 1), 1, '{gst_pkg::ST_OK, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_RELEASE, 0, 0, 0, 1, 0), 1,
                     '{gst_pkg::ST_UNDERFLOW, 1, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_ACQUIRE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0),
                     1, '{gst_pkg::ST_OK, 1, 0, 1}});
    rows.push_back('{mk(gst_pkg::OP_REMOVE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0),
                     1, '{gst_pkg::ST_OK, 1, 0, 1}});
    rows.push_back('{mk(gst_pkg::OP_BUSY, 0, 0, 0, 1, 0), 1,
                     '{gst_pkg::ST_OK, 1, 0, 1}});
    rows.push_back('{mk(gst_pkg::OP_RELEASE, 0, 0, 0, 1, 0), 1,
                     '{gst_pkg::ST_OK, 1, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_CREATE, 5, 6, 7, 0, 0), 1,
                     '{gst_pkg::ST_OK, 1, 2, 0}});
    rows.push_back('{mk(3'd7, 5, 6, 7, 0, 0), 1, '{gst_pkg::ST_NOT_FOUND, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_FIND_COORD, 5, 6, 7, 0, 0), 0, '0});
    // lease saturation on slot 1
    for (int i = 0; i < 256; i++)
      rows.push_back('{mk(gst_pkg::OP_ACQUIRE, 5, 6, 7, 0, 0), 0, '0});
    rows.push_back('{mk(gst_pkg::OP_BUSY, 0, 0, 0, 1, 0), 1,
                     '{gst_pkg::ST_OK, 1, 0, 1}});
    rows.push_back('{mk(gst_pkg::OP_RELEASE, 0, 0, 0, 1, 0), 0, '0});
    // fill to capacity and hit table full
    for (int i = 2; i < NSLOT; i++)
      rows.push_back('{mk(gst_pkg::OP_CREATE, 32'(i), 32'(-i), 32'hdead_0000, 0, 0),
                       0, '0});
    rows.push_back('{mk(gst_pkg::OP_CREATE, 9, 9, 9, 0, 0), 1,
                     '{gst_pkg::ST_FULL, 0, 0, 0}});
    rows.push_back('{mk(gst_pkg::OP_BUSY, 0, 0, 0, 63, 0), 1,
                     '{gst_pkg::ST_OK, 63, 0, 0}});

    foreach (rows[i]) begin
      r = rows[i].req;
      send_req(r);
      if (rows[i].fixed) begin
        void'(pending_rsp.pop_back());
        pending_rsp.push_back(rows[i].rsp);
      end
    end

    // free part of the table so random sequences start from a mixed table
    for (int i = 0; i < NSLOT; i++)
      if (bound[i] && $urandom_range(1, 0) != 0)
        send_req(mk(gst_pkg::OP_REMOVE, kx[i], ky[i], kz[i], 0, 0));

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1 || ph == 3) ? 84 : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? 84 : 0;
      if (ph == 3) begin src_idle_pct = 16; snk_stall_pct = 16; end
      for (int n = 0; n < 16; n++) begin
        if (ph == 0 && n == 4) fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
        send_req(rand_req());
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
